[hdl/assert_macros.svh]
// Assertion macros shared by the extent list splitter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge, off during reset
`define ELS_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge, off during reset
`define ELS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[hdl/els_pkg.sv]
// Shared types and constants of the extent list address splitter
`timescale 1ns / 1ps

package els_pkg;

   localparam int CountWidth = 4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_XLATE = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PAST_END = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [63:0] SIZE_UNLIMITED = 64'hFFFF_FFFF_FFFF_FFFF;

   // controller -> datapath
   typedef struct packed {
      logic accept_load;
      logic accept_xlate;
      logic find_miss;
      logic find_hit;
      logic calc;
      logic emit_zero;
      logic emit_past_end;
      logic emit_overflow;
      logic emit_chunk;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_zero;
      logic u_at_end;
      logic hit;
      logic past_end;
      logic overflow;
      logic rem_done;
   } dp_status_type;

endpackage

[hdl/els_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module els_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/els_ctrl.sv]
// Sequencer of the extent list splitter: load, find walk and chunk emission
`timescale 1ns / 1ps

module els_ctrl
   import els_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_opcode,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd,
   output logic          busy
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ZERO = 5'b00010,
      ST_FIND = 5'b00100,
      ST_CALC = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_LOAD) begin
                  ctrl_cmd.accept_load = 1'b1;
               end else begin
                  ctrl_cmd.accept_xlate = 1'b1;
                  state_in = dp_status.req_zero ? ST_ZERO : ST_FIND;
               end
            end
         end
         ST_ZERO: begin
            ctrl_cmd.emit_zero = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FIND: begin
            if (dp_status.u_at_end) begin
               state_in = ST_CALC;
            end else if (dp_status.hit) begin
               ctrl_cmd.find_hit = 1'b1;
               state_in = ST_CALC;
            end else begin
               ctrl_cmd.find_miss = 1'b1;
            end
         end
         ST_CALC: begin
            ctrl_cmd.calc = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (dp_status.past_end) begin
               ctrl_cmd.emit_past_end = 1'b1;
               state_in = ST_IDLE;
            end else if (dp_status.overflow) begin
               ctrl_cmd.emit_overflow = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctrl_cmd.emit_chunk = 1'b1;
               state_in = dp_status.rem_done ? ST_IDLE : ST_CALC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hdl/els_dp.sv]
// Datapath of the extent list splitter: extent table, walk registers, result beat
`timescale 1ns / 1ps

module els_dp
   import els_pkg::*;
#(
   parameter int MAX_EXTENTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          ctrl_cmd,
   output dp_status_type         dp_status,
   input  logic                  csr_write_enable,
   input  logic [CountWidth-1:0] csr_write_data,
   input  logic [2:0]            req_entry_index,
   input  logic [62:0]           req_entry_start,
   input  logic [63:0]           req_entry_bytes,
   input  logic [62:0]           req_logical_addr,
   input  logic [31:0]           req_request_bytes,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_extent_number,
   output logic [62:0]           rsp_physical_offset,
   output logic [31:0]           rsp_chunk_bytes,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   localparam int AW       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int UsedCap  = (MAX_EXTENTS > 15) ? 15 : MAX_EXTENTS;
   localparam int RamWidth = 127;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] used;
   logic [CountWidth-1:0] u_ff, u_in;
   logic [62:0]           addr_ff;
   logic [31:0]           rem_ff;
   logic [63:0]           cur_ff;
   logic [63:0]           skip_ff;
   logic [62:0]           phys_ff;
   logic [63:0]           room_ff;
   logic                  ovf_ff;
   logic                  past_end_ff;

   logic                  ram_we;
   logic [RamWidth-1:0]   ram_rd;
   logic [62:0]           ent_start;
   logic [63:0]           ent_size;
   logic [64:0]           end_sum;
   logic [64:0]           phys_sum;
   logic [31:0]           take;
   logic [31:0]           rem_left;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_ext_ff;
   logic [62:0]           rsp_phys_ff;
   logic [31:0]           rsp_bytes_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_last_ff;

   // count above the table saturates
   assign used = (count_ff > CountWidth'(UsedCap)) ? CountWidth'(UsedCap) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountWidth'(1);
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // read address follows the next extent index so data lines up with u_ff
   always_comb begin
      u_in = u_ff;
      if (ctrl_cmd.accept_xlate) begin
         u_in = '0;
      end else if (ctrl_cmd.find_miss || ctrl_cmd.emit_chunk) begin
         u_in = u_ff + CountWidth'(1);
      end
   end

   assign ram_we = ctrl_cmd.accept_load && (int'(req_entry_index) < MAX_EXTENTS);

   els_ram #(
      .WIDTH (RamWidth),
      .DEPTH (MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_start, req_entry_bytes}),
      .rd_addr (AW'(u_in)),
      .rd_data (ram_rd)
   );

   assign ent_start = ram_rd[126:64];
   assign ent_size  = ram_rd[63:0];

   // a carry out of the running end means the extent covers everything left
   assign end_sum  = {1'b0, cur_ff} + {1'b0, ent_size};
   assign phys_sum = {2'b00, ent_start} + {1'b0, skip_ff};
   assign take     = (room_ff < {32'd0, rem_ff}) ? room_ff[31:0] : rem_ff;
   assign rem_left = rem_ff - take;

   always_comb begin
      dp_status          = '0;
      dp_status.req_zero = (req_request_bytes == 32'd0);
      dp_status.u_at_end = (u_ff >= used);
      dp_status.hit      = (ent_size == SIZE_UNLIMITED) || ({2'b00, addr_ff} < end_sum);
      dp_status.past_end = past_end_ff;
      dp_status.overflow = ovf_ff;
      dp_status.rem_done = (rem_left == 32'd0);
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      if (ctrl_cmd.accept_xlate) begin
         addr_ff <= req_logical_addr;
         rem_ff  <= req_request_bytes;
         cur_ff  <= '0;
         skip_ff <= '0;
      end
      if (ctrl_cmd.find_miss) begin
         cur_ff <= end_sum[63:0];
      end
      if (ctrl_cmd.find_hit) begin
         skip_ff <= {1'b0, addr_ff} - cur_ff;
      end
      if (ctrl_cmd.calc) begin
         phys_ff     <= phys_sum[62:0];
         ovf_ff      <= (phys_sum[64:63] != 2'b00);
         room_ff     <= ent_size - skip_ff;
         past_end_ff <= (u_ff >= used);
      end
      if (ctrl_cmd.emit_chunk) begin
         rem_ff  <= rem_left;
         skip_ff <= '0;
      end
   end

   // result beat register: each beat is a one-cycle strobe, receiver cannot stall
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_cmd.emit_zero || ctrl_cmd.emit_past_end
                         || ctrl_cmd.emit_overflow || ctrl_cmd.emit_chunk;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.emit_chunk) begin
         rsp_ext_ff    <= 3'(u_ff);
         rsp_phys_ff   <= phys_ff;
         rsp_bytes_ff  <= take;
         rsp_status_ff <= STATUS_OK;
         rsp_last_ff   <= (rem_left == 32'd0);
      end else if (ctrl_cmd.emit_zero || ctrl_cmd.emit_past_end
                   || ctrl_cmd.emit_overflow) begin
         rsp_ext_ff    <= '0;
         rsp_phys_ff   <= '0;
         rsp_bytes_ff  <= '0;
         rsp_last_ff   <= 1'b1;
         if (ctrl_cmd.emit_past_end) begin
            rsp_status_ff <= STATUS_PAST_END;
         end else if (ctrl_cmd.emit_overflow) begin
            rsp_status_ff <= STATUS_OVERFLOW;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_extent_number   = rsp_ext_ff;
   assign rsp_physical_offset = rsp_phys_ff;
   assign rsp_chunk_bytes     = rsp_bytes_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

[hdl/extent_list_address_splitter_top.sv]
// Top level of the extent list address splitter
`timescale 1ns / 1ps
// Load beat: taken while idle, no result. Translate beat: a find walk that steps over
// extents until one covers the address or the table ends, then a calc and an emit step
// per result beat (chunk or error). Zero-length: one beat, no walk. busy drops as the
// last beat goes out, so the next beat may be taken with it; at most nine results per
// item. Sync reset: extent count 1, idle, table not cleared.

`include "assert_macros.svh"

module extent_list_address_splitter_top
   import els_pkg::*;
#(
   parameter int MAX_EXTENTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [2:0]            req_entry_index,
   input  logic [62:0]           req_entry_start,
   input  logic [63:0]           req_entry_bytes,
   input  logic [62:0]           req_logical_addr,
   input  logic [31:0]           req_request_bytes,
   // extent count register
   input  logic                  csr_write_enable,
   input  logic [CountWidth-1:0] csr_write_data,
   // result channel, one beat per cycle of rsp_valid
   output logic                  rsp_valid,
   output logic [2:0]            rsp_extent_number,
   output logic [62:0]           rsp_physical_offset,
   output logic [31:0]           rsp_chunk_bytes,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // qualifiers for the checks below
   logic          beat_mid;
   logic          beat_err;
   logic          take_load;

   // sequencer: idle/load, zero-length, find walk, per-chunk calc and emit
   els_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .dp_status  (dp_status),
      .ctrl_cmd   (ctrl_cmd),
      .busy       (busy)
   );

   // extent table, running logical end, skip, room and result beat register
   els_dp #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl_cmd            (ctrl_cmd),
      .dp_status           (dp_status),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_entry_index     (req_entry_index),
      .req_entry_start     (req_entry_start),
      .req_entry_bytes     (req_entry_bytes),
      .req_logical_addr    (req_logical_addr),
      .req_request_bytes   (req_request_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_extent_number   (rsp_extent_number),
      .rsp_physical_offset (rsp_physical_offset),
      .rsp_chunk_bytes     (rsp_chunk_bytes),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last)
   );

   assign beat_mid  = rsp_valid && !rsp_last;
   assign beat_err  = rsp_valid && (rsp_status != STATUS_OK);
   assign take_load = start && !busy && (req_opcode == OP_LOAD);

   // a beat that is not the last leaves the sequencer mid-run
   `ELS_ASSERT_NOW(a_midrun_busy, clock, reset, beat_mid, busy, "non-last beat while idle")
   // an error beat always closes the run
   `ELS_ASSERT_NOW(a_err_last, clock, reset, beat_err, rsp_last, "error beat without last")
   // a load never produces a beat and never leaves idle
   `ELS_ASSERT_NEXT(a_load_quiet, clock, reset, take_load, !rsp_valid && !busy, "load activity")

endmodule

[tb/sv/extent_chunk_check_pkg.sv]
// Beat types and the chunk scoreboard for the extent list splitter bench
`timescale 1ns / 1ps

package extent_chunk_check_pkg;

   import els_pkg::*;

   localparam int TABLE_DEPTH = 8;
   localparam logic [63:0] OFFSET_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  index;
      logic [62:0] base;
      logic [63:0] size;
      logic [62:0] addr;
      logic [31:0] length;
   } request_type;

   typedef struct packed {
      logic [2:0]  extent;
      logic [62:0] offset;
      logic [31:0] length;
      logic [1:0]  status;
      logic        last;
   } chunk_type;

   class chunk_ledger_type;
      logic [62:0]           bases [TABLE_DEPTH];
      logic [63:0]           sizes [TABLE_DEPTH];
      logic [CountWidth-1:0] count;
      chunk_type             awaited [$];
      int                    errors;

      function new();
         count  = CountWidth'(1);
         errors = 0;
         foreach (bases[i]) begin
            bases[i] = '0;
            sizes[i] = '0;
         end
      endfunction

      function void set_count(logic [CountWidth-1:0] value);
         count = value;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function void await_chunk(logic [2:0] extent, logic [62:0] offset,
                                logic [31:0] length, logic [1:0] status,
                                logic last);
         chunk_type c;
         c.extent = extent;
         c.offset = offset;
         c.length = length;
         c.status = status;
         c.last   = last;
         awaited.push_back(c);
      endfunction

      // load beats update the table; translate beats queue their chunks
      function void note_beat(request_type r);
         logic [63:0] addr, cur, skip, rest, room, take, phys;
         logic [64:0] reach;
         int unsigned used, u;
         bit          hit;
         if (r.opcode == OP_LOAD) begin
            bases[r.index] = r.base;
            sizes[r.index] = r.size;
            return;
         end
         used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         addr = {1'b0, r.addr};
         rest = {32'b0, r.length};
         if (rest == 0) begin
            await_chunk('0, '0, '0, STATUS_OK, 1'b1);
            return;
         end
         // locate the first extent that covers the address
         cur  = '0;
         skip = '0;
         u    = 0;
         hit  = 1'b0;
         while (!hit && u < used) begin
            reach = {1'b0, cur} + {1'b0, sizes[u]};
            if (sizes[u] == SIZE_UNLIMITED || reach[64] || addr < reach[63:0]) begin
               hit  = 1'b1;
               skip = addr - cur;
            end else begin
               cur = reach[63:0];
               u++;
            end
         end
         // one chunk per extent crossed
         while (rest != 0) begin
            if (u >= used) begin
               await_chunk('0, '0, '0, STATUS_PAST_END, 1'b1);
               return;
            end
            phys = {1'b0, bases[u]} + skip;
            if (phys > OFFSET_CEILING) begin
               await_chunk('0, '0, '0, STATUS_OVERFLOW, 1'b1);
               return;
            end
            room = sizes[u] - skip;
            take = (room < rest) ? room : rest;
            rest = rest - take;
            await_chunk(u[2:0], phys[62:0], take[31:0], STATUS_OK, rest == 0);
            skip = '0;
            u++;
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task check_chunk(chunk_type got);
         chunk_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("unexpected chunk ext=%0d off=%0h len=%0h st=%0d",
                                      got.extent, got.offset, got.length, got.status));
            return;
         end
         want = awaited.pop_front();
         if (got.extent !== want.extent)
            report_mismatch($sformatf("extent %0d, want %0d", got.extent, want.extent));
         if (got.offset !== want.offset)
            report_mismatch($sformatf("offset %0h, want %0h", got.offset, want.offset));
         if (got.length !== want.length)
            report_mismatch($sformatf("length %0h, want %0h", got.length, want.length));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      endtask
   endclass

endpackage

[tb/sv/extent_list_address_splitter_top_tb.sv]
// Top level bench for the extent list address splitter
`timescale 1ns / 1ps

module extent_list_address_splitter_top_tb;

   import els_pkg::*;
   import extent_chunk_check_pkg::*;

   // run limits: the slowest beat is a translate with nine results after a long
   // sender gap; CLOCK_LIMIT is many times the worst case
   localparam int CLOCK_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;   // covers a full eight-extent walk
   localparam int PHASE_BEATS   = 85;

   localparam logic [62:0] TOP_OFFSET = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_opcode = OP_LOAD;
   logic [2:0]            req_entry_index = '0;
   logic [62:0]           req_entry_start = '0;
   logic [63:0]           req_entry_bytes = '0;
   logic [62:0]           req_logical_addr = '0;
   logic [31:0]           req_request_bytes = '0;
   logic                  csr_write_enable = 1'b0;
   logic [CountWidth-1:0] csr_write_data = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_extent_number;
   logic [62:0]           rsp_physical_offset;
   logic [31:0]           rsp_chunk_bytes;
   logic [1:0]            rsp_status;
   logic                  rsp_last;

   chunk_ledger_type ledger;
   int               beats_taken = 0;
   int               cycles = 0;

   extent_list_address_splitter_top #(
      .MAX_EXTENTS(TABLE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_entry_index    (req_entry_index),
      .req_entry_start    (req_entry_start),
      .req_entry_bytes    (req_entry_bytes),
      .req_logical_addr   (req_logical_addr),
      .req_request_bytes  (req_request_bytes),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_extent_number  (rsp_extent_number),
      .rsp_physical_offset(rsp_physical_offset),
      .rsp_chunk_bytes    (rsp_chunk_bytes),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CLOCK_LIMIT) begin
         $display("extent_list_address_splitter_top test failed");
         $finish;
      end
   end

   // Sample everything at the rising edge. Inputs only move on the falling
   // edge, so the beat fields are stable here. A config write, an accepted
   // beat and a result strobe are all observed in the same place so the
   // ledger sees them in edge order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            ledger.set_count(csr_write_data);
         if (start && !busy) begin
            ledger.note_beat({req_opcode, req_entry_index, req_entry_start,
                              req_entry_bytes, req_logical_addr, req_request_bytes});
            beats_taken++;
         end
         // results cannot be held off, so every strobe is a beat
         if (rsp_valid)
            ledger.check_chunk({rsp_extent_number, rsp_physical_offset,
                                rsp_chunk_bytes, rsp_status, rsp_last});
      end
   end

   // Entered and left at a falling edge. start may still be high from the
   // previous beat; it is either lowered for a gap or kept high with new
   // fields, never both in one step.
   task send_beat(input request_type r, input int idle_pct);
      int taken;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= r.opcode;
      req_entry_index   <= r.index;
      req_entry_start   <= r.base;
      req_entry_bytes   <= r.size;
      req_logical_addr  <= r.addr;
      req_request_bytes <= r.length;
      taken = beats_taken;
      // the monitor counts the beat at the rising edge that takes it
      do @(negedge clock); while (beats_taken == taken);
   endtask

   task load_entry(input logic [2:0] index, input logic [62:0] base,
                   input logic [63:0] size);
      request_type r;
      r        = '0;
      r.opcode = OP_LOAD;
      r.index  = index;
      r.base   = base;
      r.size   = size;
      send_beat(r, 0);
   endtask

   task translate(input logic [62:0] addr, input logic [31:0] length);
      request_type r;
      r        = '0;
      r.opcode = OP_XLATE;
      r.addr   = addr;
      r.length = length;
      send_beat(r, 0);
   endtask

   // Wait for every expected chunk, then let a full walk's worth of cycles
   // pass: a load beat has no result, so an empty queue alone says little.
   task drain_idle();
      start <= 1'b0;
      while (ledger.outstanding() != 0 || busy)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_count(input logic [CountWidth-1:0] value);
      drain_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly small extents and addresses inside the mapped span, so walks cross
   // several extents; now and then full-range values, unlimited or huge sizes,
   // and starts near the top of the offset range to hit the overflow path.
   task random_beat(input int idle_pct);
      request_type r;
      int          pick;
      r.opcode = 1'($urandom_range(0, 1));
      r.index  = 3'($urandom);
      r.base   = 63'({$urandom, $urandom});
      r.size   = {$urandom, $urandom};
      r.addr   = 63'({$urandom, $urandom});
      r.length = $urandom;
      if ($urandom_range(0, 99) < 25) begin
         r.opcode = OP_LOAD;
         pick = $urandom_range(0, 3);
         if (pick == 1)
            r.base = TOP_OFFSET - 63'($urandom_range(0, 4000));
         else if (pick > 1)
            r.base = 63'($urandom_range(0, 1 << 20));
         pick = $urandom_range(0, 19);
         if (pick == 0)
            r.size = SIZE_UNLIMITED;
         else if (pick == 2)
            r.size = '0;
         else if (pick > 2)
            r.size = 64'($urandom_range(1, 300));
      end else begin
         r.opcode = OP_XLATE;
         if ($urandom_range(0, 99) < 80)
            r.addr = 63'($urandom_range(0, 1500));
         pick = $urandom_range(0, 99);
         if (pick < 8)
            r.length = '0;
         else if (pick >= 20)
            r.length = $urandom_range(1, 600);
      end
      send_beat(r, idle_pct);
   endtask

   int idle_mix [3] = '{30, 69, 0};

   initial begin
      logic [CountWidth-1:0] phase_count [3];
      ledger = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole table first so no walk ever reads an unwritten entry
      load_entry(3'd0, '0, 64'd100);
      load_entry(3'd1, TOP_OFFSET, 64'd0);              // zero-size extent
      load_entry(3'd2, 63'd5000, 64'd50);
      load_entry(3'd3, TOP_OFFSET, 64'd1000);           // start at the top
      load_entry(3'd4, 63'd12345, 64'hFFFF_FFFF_FFFF_FFF0); // end wraps 2^64
      load_entry(3'd5, 63'd777, SIZE_UNLIMITED);
      load_entry(3'd6, 63'h2AAA_AAAA_AAAA_AAAA, 64'd16);
      load_entry(3'd7, 63'h5555_5555_5555_5555, 64'd16);

      write_count(4'd8);
      translate(TOP_OFFSET, 32'd0);         // zero length
      translate(63'd0, 32'd300);            // crosses the zero-size extent
      translate(63'd120, 32'd10);           // starts mid-extent
      translate(63'd160, 32'd5);            // start + skip overflows
      translate(63'd1150, 32'hFFFF_FFFF);   // lands on the wrapping extent
      translate(TOP_OFFSET, 32'hFFFF_FFFF); // wrapping extent covers the top

      write_count(4'd3);
      translate(63'd0, 32'd1000);           // runs off the end after 3 chunks

      write_count(4'd0);
      translate(63'd5, 32'd7);              // no extents: past end at once
      translate(63'd9, 32'd0);

      write_count(4'd15);                   // saturates to the table depth
      translate(63'd0, 32'd100000);

      write_count(4'd1);
      load_entry(3'd0, '0, SIZE_UNLIMITED);
      translate(TOP_OFFSET, 32'hFFFF_FFFF); // unlimited extent

      // random phases: sender gaps at 30%, then 69%, then back to back
      phase_count[0] = 4'd8;
      phase_count[1] = CountWidth'($urandom_range(2, 7));
      phase_count[2] = 4'd15;
      for (int p = 0; p < 3; p++) begin
         write_count(phase_count[p]);
         repeat (PHASE_BEATS) random_beat(idle_mix[p]);
      end

      drain_idle();
      if (ledger.errors == 0 && ledger.outstanding() == 0)
         $display("extent_list_address_splitter_top test passed");
      else
         $display("extent_list_address_splitter_top test failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/els_pkg.sv
hdl/els_ram.sv
hdl/els_ctrl.sv
hdl/els_dp.sv
hdl/extent_list_address_splitter_top.sv
tb/sv/extent_chunk_check_pkg.sv
tb/sv/extent_list_address_splitter_top_tb.sv
